/* src/glpf_pkg.sv */
`default_nettype none

package glpf_pkg;

  localparam int DEF_MAX_COLS  = 32;
  localparam int DEF_ELEV_BITS = 16;

  localparam int ROW_W       = 10;
  localparam int COL_W       = 5;
  localparam int CFG_COLS_W  = 6;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_ADDR_W  = 1;
  localparam int OUT_TDATA_W = ((ROW_W + COL_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = 1'b1;

  localparam logic [ROW_W-1:0]      ROWS_RESET = 10'd5;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 6'd5;

  // per-item control carried through the command queue
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             end_of_grid;
  } cmd_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0] peak_row;
    logic [COL_W-1:0] peak_col;
    logic             last_of_run;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EVAL,
    BK_SWRD,
    BK_SWEV,
    BK_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

/* src/glpf_front.sv */
`default_nettype none

module glpf_front import glpf_pkg::*; #(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int ELEV_BITS = DEF_ELEV_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ELEV_BITS-1:0]  in_elev,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_ctl_t                   cmd_ctl,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cmd_col,
  output logic [ELEV_BITS-1:0]       cmd_cell,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0]   cols_eff
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ROW_W-1:0]      cfg_rows_r, cfg_rows_nxt;
  logic [CFG_COLS_W-1:0] cfg_cols_r, cfg_cols_nxt;
  logic [ROW_W-1:0]      row_pos_r, row_pos_nxt;
  logic [AW-1:0]         col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0]      rows_eff;
  logic                  wrap;
  logic [ROW_W-1:0]      cur_row;
  logic [AW-1:0]         cur_col;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_eff = (AW + 1)'(1);
    end else if (32'(cfg_cols_r) > MAX_COLS) begin
      cols_eff = (AW + 1)'(MAX_COLS);
    end else begin
      cols_eff = (AW + 1)'(cfg_cols_r);
    end
    rows_eff = (cfg_rows_r == '0) ? ROW_W'(1) : cfg_rows_r;
  end

  // a position left outside the grid by a register write restarts the grid
  always_comb begin
    wrap     = (row_pos_r >= rows_eff) || ({1'b0, col_pos_r} >= cols_eff);
    cur_row  = wrap ? '0 : row_pos_r;
    cur_col  = wrap ? '0 : col_pos_r;
    last_col = ({1'b0, cur_col} + (AW + 1)'(1)) == cols_eff;
    last_row = ({1'b0, cur_row} + (ROW_W + 1)'(1)) == {1'b0, rows_eff};
  end

  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (accept) begin
      if (last_col && last_row) begin
        row_pos_nxt = '0;
        col_pos_nxt = '0;
      end else if (last_col) begin
        row_pos_nxt = cur_row + ROW_W'(1);
        col_pos_nxt = '0;
      end else begin
        row_pos_nxt = cur_row;
        col_pos_nxt = cur_col + AW'(1);
      end
    end
  end

  always_comb begin
    cfg_rows_nxt = cfg_rows_r;
    cfg_cols_nxt = cfg_cols_r;
    if (cfg_valid) begin
      case (cfg_addr)
        CFG_GRID_ROWS: cfg_rows_nxt = cfg_data[ROW_W-1:0];
        CFG_GRID_COLS: cfg_cols_nxt = cfg_data[CFG_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= ROWS_RESET;
      cfg_cols_r <= COLS_RESET;
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else begin
      cfg_rows_r <= cfg_rows_nxt;
      cfg_cols_r <= cfg_cols_nxt;
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
    end
  end

  assign q_push              = accept;
  assign cmd_ctl.row         = cur_row;
  assign cmd_ctl.end_of_grid = last_col && last_row;
  assign cmd_col             = cur_col;
  assign cmd_cell            = in_elev;

endmodule

`default_nettype wire

/* src/glpf_cmd_fifo.sv */
`default_nettype none

module glpf_cmd_fifo import glpf_pkg::*; #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  input  wire logic          pop,
  output logic [DW-1:0]      dout,
  output logic               full,
  output logic               empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* src/glpf_back.sv */
`default_nettype none

module glpf_back import glpf_pkg::*; #(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int ELEV_BITS = DEF_ELEV_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0]   cols_eff,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire cmd_ctl_t             q_ctl,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
  input  wire logic [ELEV_BITS-1:0] q_cell,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output result_t                   res
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // row stores: a holds the latest row per column, b the one before
  logic signed [ELEV_BITS-1:0] mem_a [MAX_COLS];
  logic signed [ELEV_BITS-1:0] mem_b [MAX_COLS];

  back_state_t                 state_r, state_nxt;
  logic [ROW_W-1:0]            cmd_row_r;
  logic [AW-1:0]               cmd_col_r;
  logic signed [ELEV_BITS-1:0] cmd_cell_r;
  logic                        cmd_eog_r;
  logic [AW-1:0]               k_r, k_nxt;
  logic signed [ELEV_BITS-1:0] left_r, left_nxt;
  logic signed [ELEV_BITS-1:0] a0_r, a1_r, b0_r;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [ROW_W-1:0]            pend_row_r, pend_row_nxt;
  logic [AW-1:0]               pend_col_r, pend_col_nxt;
  logic                        out_valid_r, out_valid_nxt;
  result_t                     out_res_r, out_res_nxt;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr0, rd_addr1;
  logic                        wr_en;
  logic                        sweep;
  logic [AW-1:0]               pos;
  logic signed [ELEV_BITS-1:0] self_v, up_v, down_v, left_v, right_v;
  logic                        cand;
  logic [ROW_W-1:0]            cand_row;
  logic                        can_emit;
  logic                        stall;
  logic                        push;
  result_t                     push_res;

  assign can_emit  = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  // neighbour selection for either a single decision or the last-row sweep
  always_comb begin
    sweep   = (state_r == BK_SWEV);
    pos     = sweep ? k_r : cmd_col_r;
    self_v  = a0_r;
    if (sweep) begin
      up_v = (cmd_row_r != '0) ? b0_r : self_v;
    end else begin
      up_v = (cmd_row_r >= ROW_W'(2)) ? b0_r : self_v;
    end
    down_v  = sweep ? self_v : cmd_cell_r;
    left_v  = (pos != '0) ? left_r : self_v;
    right_v = (({1'b0, pos} + (AW + 1)'(1)) < cols_eff) ? a1_r : self_v;
    cand    = (sweep || cmd_row_r != '0) &&
              (self_v >= up_v) && (self_v >= down_v) &&
              (self_v >= left_v) && (self_v >= right_v);
    cand_row = sweep ? cmd_row_r : cmd_row_r - ROW_W'(1);
    stall    = cand && pend_valid_r && !can_emit;
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    left_nxt       = left_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr0       = q_col;
    rd_addr1       = q_col + AW'(1);
    wr_en          = 1'b0;
    push           = 1'b0;
    push_res       = '{peak_row: pend_row_r, peak_col: COL_W'(pend_col_r), last_of_run: 1'b0};

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          state_nxt = BK_EVAL;
        end
      end
      BK_SWRD: begin
        rd_en     = 1'b1;
        rd_addr0  = k_r;
        rd_addr1  = k_r + AW'(1);
        state_nxt = BK_SWEV;
      end
      BK_EVAL, BK_SWEV: begin
        if (!stall) begin
          if (cand) begin
            // an earlier result of this run is now known not to be the last
            push           = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_row_nxt   = cand_row;
            pend_col_nxt   = pos;
          end
          left_nxt = a0_r;
          if (state_r == BK_EVAL) begin
            wr_en = 1'b1;
            if (cmd_eog_r) begin
              k_nxt     = '0;
              state_nxt = BK_SWRD;
            end else begin
              state_nxt = (cand || pend_valid_r) ? BK_FLUSH : BK_IDLE;
            end
          end else if (({1'b0, k_r} + (AW + 1)'(1)) == cols_eff) begin
            state_nxt = (cand || pend_valid_r) ? BK_FLUSH : BK_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = BK_SWRD;
          end
        end
      end
      BK_FLUSH: begin
        if (can_emit) begin
          push                 = 1'b1;
          push_res.last_of_run = 1'b1;
          pend_valid_nxt       = 1'b0;
          state_nxt            = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push_res;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    left_r     <= left_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    out_res_r  <= out_res_nxt;
    if (q_pop) begin
      cmd_row_r  <= q_ctl.row;
      cmd_eog_r  <= q_ctl.end_of_grid;
      cmd_col_r  <= q_col;
      cmd_cell_r <= q_cell;
    end
  end

  // row stores: registered reads, one write per store
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a0_r <= mem_a[rd_addr0];
      a1_r <= mem_a[rd_addr1];
      b0_r <= mem_b[rd_addr0];
    end
    if (wr_en) begin
      mem_a[cmd_col_r] <= cmd_cell_r;
      mem_b[cmd_col_r] <= a0_r;
    end
  end

endmodule

`default_nettype wire

/* src/grid_local_peak_finder_top.sv */
// result path: command queue, then BK_IDLE pops and BK_EVAL decides; results leave via a register
// the back end finishes a cell before popping the next, plus BK_FLUSH when it found a peak
// end of grid: a last-row sweep follows, BK_SWRD then BK_SWEV per column, then any BK_FLUSH
// a 2-entry command queue lets the input run ahead while the back end is busy
// reset: synchronous active-low rst_n; position, queue and output clear, config to 5x5
// row stores are not cleared and hold undefined data until written
`default_nettype none

module grid_local_peak_finder_top import glpf_pkg::*; #(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int ELEV_BITS = DEF_ELEV_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream, one cell per transfer in row-major order
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [((ELEV_BITS + 7) / 8) * 8 - 1:0] in_tdata, // elevation
  // result stream, one peak per transfer
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [OUT_TDATA_W-1:0]               out_tdata,  // peak_row, peak_col, zero pad
  output logic                                 out_tlast,  // last_of_run
  // configuration writes: index 0 grid_rows, index 1 grid_cols
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0]           cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]           cfg_data
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DW = ELEV_BITS + AW + $bits(cmd_ctl_t);

  cmd_ctl_t             cmd_ctl, q_ctl;
  logic [AW-1:0]        cmd_col, q_col;
  logic [ELEV_BITS-1:0] cmd_cell, q_cell;
  logic [AW:0]          cols_eff;
  logic                 q_push, q_pop, q_full, q_empty;
  logic [DW-1:0]        q_dout;
  result_t              res;

  // front: position tracking, config registers, tagging of each cell with row, column and grid end
  glpf_front #(
    .MAX_COLS  (MAX_COLS),
    .ELEV_BITS (ELEV_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_elev   (in_tdata[ELEV_BITS-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd_ctl   (cmd_ctl),
    .cmd_col   (cmd_col),
    .cmd_cell  (cmd_cell),
    .cols_eff  (cols_eff)
  );

  // command queue between front and back
  glpf_cmd_fifo #(
    .DW (DW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({cmd_cell, cmd_col, cmd_ctl}),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_ctl  = q_dout[$bits(cmd_ctl_t)-1:0];
  assign q_col  = q_dout[$bits(cmd_ctl_t) +: AW];
  assign q_cell = q_dout[$bits(cmd_ctl_t) + AW +: ELEV_BITS];

  // back: row stores, peak decisions, last-row sweep and output register
  glpf_back #(
    .MAX_COLS  (MAX_COLS),
    .ELEV_BITS (ELEV_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cols_eff  (cols_eff),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_col     (q_col),
    .q_cell    (q_cell),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result fields, row in the low bits
  assign out_tdata = OUT_TDATA_W'({res.peak_col, res.peak_row});
  assign out_tlast = res.last_of_run;

endmodule

`default_nettype wire

/* src/glpf_checker.sv */
`default_nettype none

module glpf_checker import glpf_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // rows never exceed 1022, the highest row of a 1023-row grid
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ROW_W-1:0] != {ROW_W{1'b1}})
    else $error("peak row out of range");

  // padding above the column field stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1] == 1'b0)
    else $error("nonzero padding in result");

endmodule

bind grid_local_peak_finder_top glpf_checker u_glpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* sim/grid_local_peak_finder_top_tb.sv */
`timescale 1ns / 100ps

module grid_local_peak_finder_top_tb;
  import glpf_pkg::*;

  localparam int MAX_COLS      = DEF_MAX_COLS;
  localparam int ELEV_W        = DEF_ELEV_BITS;
  localparam int IN_TDATA_W    = ((ELEV_W + 7) / 8) * 8;
  // generous bound: worst stalls on every transfer, several times over
  localparam int CYCLE_LIMIT   = 3000000;
  // idle time before a register write: queued cells plus a full 32-column sweep
  localparam int SETTLE_CYCLES = 120;
  localparam int RAND_CELLS    = 350;
  localparam int MAX_REPORTS   = 10;
  localparam int DIR_LEN       = 31;

  // directed step kinds, input pacing and terrain shapes
  typedef enum logic [1:0] {STEP_CFG, STEP_CELL} step_kind_t;
  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;
  typedef enum int {
    TERRAIN_NOISE,
    TERRAIN_LOW,
    TERRAIN_FLAT,
    TERRAIN_EXTREME,
    TERRAIN_SLOPE
  } terrain_t;

  // one row of the directed table; typed rows carry their known peak
  typedef struct packed {
    step_kind_t              kind;
    logic [CFG_ADDR_W-1:0]   reg_idx;
    logic [15:0]             value;
    logic                    typed;
    result_t                 typed_peak;
  } dir_step_t;

  localparam result_t NO_PEAK   = '0;
  // a 1x1 grid reports its only cell as the last peak of the run
  localparam result_t LONE_PEAK = '{peak_row: '0, peak_col: '0, last_of_run: 1'b1};

  localparam dir_step_t DIR_TAB [DIR_LEN] = '{
    // zero rows and zero columns both act as one: every cell is a 1x1 grid
    '{STEP_CFG,  CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CFG,  CFG_GRID_COLS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h8000, 1'b1, LONE_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h7fff, 1'b1, LONE_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h0000, 1'b1, LONE_PEAK},
    // single-row grid: nothing decided until the final cell
    '{STEP_CFG,  CFG_GRID_ROWS, 16'd1,    1'b0, NO_PEAK},
    '{STEP_CFG,  CFG_GRID_COLS, 16'd3,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd5,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h8000, 1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h7fff, 1'b0, NO_PEAK},
    // 3x3 with plateaus and cells of elevation one
    '{STEP_CFG,  CFG_GRID_ROWS, 16'd3,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd1,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd1,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd1,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'hffff, 1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd0,    1'b0, NO_PEAK},
    // stop a 4x4 grid in its second row
    '{STEP_CFG,  CFG_GRID_ROWS, 16'd4,    1'b0, NO_PEAK},
    '{STEP_CFG,  CFG_GRID_COLS, 16'd4,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd7,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd7,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd7,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'd7,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'hfffd, 1'b0, NO_PEAK},
    // shrink so the position falls outside the grid: next cell restarts at 0,0
    '{STEP_CFG,  CFG_GRID_COLS, 16'd1,    1'b0, NO_PEAK},
    '{STEP_CFG,  CFG_GRID_ROWS, 16'd2,    1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h8000, 1'b0, NO_PEAK},
    '{STEP_CELL, CFG_GRID_ROWS, 16'h8000, 1'b0, NO_PEAK}
  };

  // dut connections, all inputs known from time zero
  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;   // elevation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // peak_row, peak_col, zero pad
  logic                  out_tlast;         // last_of_run
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  grid_local_peak_finder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // peak predictor state: settings, two row stores and the scan position
  logic [ROW_W-1:0]        model_rows = ROWS_RESET;
  logic [CFG_COLS_W-1:0]   model_cols = COLS_RESET;
  logic signed [ELEV_W-1:0] prior_elev [MAX_COLS];
  logic signed [ELEV_W-1:0] older_elev [MAX_COLS];
  int                      row_at = 0;
  int                      col_at = 0;

  result_t  peak_q[$];       // peaks still owed by the dut, oldest first
  result_t  fresh_peaks[$];  // peaks caused by the latest cell

  pace_t    src_pace  = PACE_LIGHT;
  pace_t    sink_pace = PACE_LIGHT;
  int       sink_hold = 0;
  logic [ELEV_W-1:0] drift_elev = '0;

  int       mismatches   = 0;
  int       peaks_seen   = 0;
  int       cells_sent   = 0;
  int       cfg_writes   = 0;
  logic     grid_in_flight = 1'b0;
  int unsigned cycle_cnt = 0;

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_rows(input logic [ROW_W-1:0] rows);
    return (rows == '0) ? 1 : int'(rows);
  endfunction

  function automatic int eff_cols(input logic [CFG_COLS_W-1:0] cols);
    if (cols == '0)
      return 1;
    return (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
  endfunction

  // advance the predictor by one cell and collect the peaks it decides
  function automatic void predict_cell(input logic signed [ELEV_W-1:0] new_elev);
    int      rows, cols, r, c;
    logic signed [ELEV_W-1:0] mid_e, up_e, left_e, right_e;
    result_t pk;
    rows = eff_rows(model_rows);
    cols = eff_cols(model_cols);
    fresh_peaks.delete();
    // a position left outside the grid by a register write starts a new grid
    if (row_at >= rows || col_at >= cols) begin
      row_at = 0;
      col_at = 0;
    end
    r = row_at;
    c = col_at;

    // the new cell is the lower neighbour of the cell above it
    if (r >= 1) begin
      mid_e   = prior_elev[c];
      up_e    = (r >= 2) ? older_elev[c] : mid_e;
      left_e  = (c > 0) ? older_elev[c-1] : mid_e;
      right_e = (c + 1 < cols) ? prior_elev[c+1] : mid_e;
      if (mid_e >= up_e && mid_e >= new_elev && mid_e >= left_e && mid_e >= right_e) begin
        pk.peak_row    = ROW_W'(r - 1);
        pk.peak_col    = COL_W'(c);
        pk.last_of_run = 1'b0;
        fresh_peaks.push_back(pk);
      end
    end
    older_elev[c] = prior_elev[c];
    prior_elev[c] = new_elev;

    if (r + 1 == rows && c + 1 == cols) begin
      // last cell of the grid: sweep the whole last row, bottom edge mirrors itself
      for (int k = 0; k < cols; k++) begin
        mid_e   = prior_elev[k];
        up_e    = (r >= 1) ? older_elev[k] : mid_e;
        left_e  = (k > 0) ? prior_elev[k-1] : mid_e;
        right_e = (k + 1 < cols) ? prior_elev[k+1] : mid_e;
        if (mid_e >= up_e && mid_e >= left_e && mid_e >= right_e) begin
          pk.peak_row    = ROW_W'(r);
          pk.peak_col    = COL_W'(k);
          pk.last_of_run = 1'b0;
          fresh_peaks.push_back(pk);
        end
      end
      row_at = 0;
      col_at = 0;
    end else if (c + 1 == cols) begin
      col_at = 0;
      row_at = r + 1;
    end else begin
      col_at = c + 1;
    end

    if (fresh_peaks.size() > 0) begin
      pk = fresh_peaks.pop_back();
      pk.last_of_run = 1'b1;
      fresh_peaks.push_back(pk);
    end
  endfunction

  // gap lengths: mostly short, a few long
  function automatic int draw_gap(input pace_t pace);
    int roll;
    roll = $urandom_range(0, 99);
    case (pace)
      PACE_FULL:  return 0;
      PACE_LIGHT: return (roll < 70) ? 0 : ((roll < 97) ? $urandom_range(1, 3)
                                                        : $urandom_range(6, 20));
      default:    return (roll < 40) ? 0 : ((roll < 90) ? $urandom_range(1, 4)
                                                        : $urandom_range(8, 40));
    endcase
  endfunction

  function automatic logic [ELEV_W-1:0] draw_elev(input terrain_t terrain,
                                                  input logic [ELEV_W-1:0] flat_level);
    case (terrain)
      TERRAIN_NOISE: return ELEV_W'($urandom);
      // values around zero give many ties
      TERRAIN_LOW:   return ELEV_W'($urandom_range(0, 4) - 2);
      TERRAIN_FLAT:  return ($urandom_range(0, 99) < 85) ? flat_level
                                                         : ELEV_W'(flat_level + 1'b1);
      TERRAIN_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: begin
        drift_elev = ELEV_W'(drift_elev + $urandom_range(0, 6) - 3);
        return drift_elev;
      end
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // one cell transfer, preceded by a random idle gap
  task automatic push_cell(input logic [ELEV_W-1:0] elev, input logic typed,
                           input result_t typed_peak);
    int gap;
    gap = draw_gap(src_pace);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(elev);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cell(elev);
    if (typed)
      peak_q.push_back(typed_peak);
    else
      foreach (fresh_peaks[i]) peak_q.push_back(fresh_peaks[i]);
    cells_sent++;
    grid_in_flight = 1'b1;
  endtask

  // stop sending, wait for every owed peak, then let the back end go quiet
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only once the block is idle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    if (grid_in_flight) begin
      drain();
      grid_in_flight = 1'b0;
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GRID_ROWS)
      model_rows = val[ROW_W-1:0];
    else
      model_cols = val[CFG_COLS_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side back-pressure: ready, then a random stall, possibly none
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
      sink_hold  <= draw_gap(sink_pace);
    end
  end

  // compare every peak transfer with the oldest owed peak
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      peaks_seen++;
      if (peak_q.size() == 0) begin
        flag_error($sformatf("unexpected peak: row %0d col %0d last %0b",
                             out_tdata[ROW_W-1:0], out_tdata[ROW_W+COL_W-1:ROW_W], out_tlast));
      end else begin
        want = peak_q.pop_front();
        if (out_tdata[ROW_W-1:0] !== want.peak_row ||
            out_tdata[ROW_W+COL_W-1:ROW_W] !== want.peak_col ||
            out_tlast !== want.last_of_run)
          flag_error($sformatf("peak %0d: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                               peaks_seen, want.peak_row, want.peak_col, want.last_of_run,
                               out_tdata[ROW_W-1:0], out_tdata[ROW_W+COL_W-1:ROW_W],
                               out_tlast));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d peaks still owed", cycle_cnt, peak_q.size());
      $display("grid_local_peak_finder_top test failed");
      $finish;
    end
  end

  initial begin
    int       rand_cells;
    int       phase;
    int       rows_pick, cols_pick;
    int       grid_cells, n_cells;
    logic     partial;
    terrain_t terrain;
    logic [ELEV_W-1:0] flat_level;

    rand_cells = 0;
    phase      = 0;

    // synchronous reset held at the start, then released
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table: extremes, degenerate sizes, ties and a mid-grid restart
    for (int i = 0; i < DIR_LEN; i++) begin
      if (DIR_TAB[i].kind == STEP_CFG)
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].value[CFG_DATA_W-1:0]);
      else
        push_cell(DIR_TAB[i].value[ELEV_W-1:0], DIR_TAB[i].typed, DIR_TAB[i].typed_peak);
    end

    // random phases: a grid setting, whole grids of random terrain, sometimes a partial one
    while (rand_cells < RAND_CELLS) begin
      partial = 1'b0;
      case (phase)
        0: begin
          // tallest grid, left unfinished
          rows_pick = 1023;
          cols_pick = 1;
          partial   = 1'b1;
        end
        1: begin
          rows_pick = 2;
          cols_pick = MAX_COLS;
        end
        2: begin
          // column count above the row buffer depth clamps to it
          rows_pick = 1;
          cols_pick = 63;
        end
        default: begin
          case ($urandom_range(0, 99)) inside
            [0:4]:   rows_pick = 0;
            [5:19]:  rows_pick = 1;
            [20:84]: rows_pick = $urandom_range(2, 6);
            [85:94]: rows_pick = $urandom_range(7, 12);
            default: begin
              rows_pick = $urandom_range(100, 1023);
              partial   = 1'b1;
            end
          endcase
          case ($urandom_range(0, 99)) inside
            [0:4]:   cols_pick = 0;
            [5:14]:  cols_pick = 1;
            [15:84]: cols_pick = $urandom_range(2, 8);
            [85:94]: cols_pick = $urandom_range(9, MAX_COLS);
            default: cols_pick = $urandom_range(MAX_COLS + 1, 63);
          endcase
          if (partial)
            cols_pick = $urandom_range(1, 2);
          else if (eff_cols(CFG_COLS_W'(cols_pick)) > 12)
            rows_pick = $urandom_range(1, 3);
        end
      endcase

      // mid-grid: pick a smaller grid so the position falls outside it and
      // the stores are never read before being written
      if ((row_at != 0 || col_at != 0) &&
          row_at < eff_rows(ROW_W'(rows_pick)) && col_at < eff_cols(CFG_COLS_W'(cols_pick))) begin
        if (row_at > 0)
          rows_pick = $urandom_range(0, row_at);
        else
          cols_pick = $urandom_range(0, col_at);
      end

      write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows_pick));
      write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols_pick));

      src_pace   = pace_t'($urandom_range(0, 2));
      sink_pace  = pace_t'($urandom_range(0, 2));
      terrain    = terrain_t'($urandom_range(0, 4));
      flat_level = ELEV_W'($urandom);
      drift_elev = ELEV_W'($urandom);

      grid_cells = eff_rows(ROW_W'(rows_pick)) * eff_cols(CFG_COLS_W'(cols_pick));
      if (partial) begin
        n_cells = $urandom_range(20, 60);
      end else begin
        n_cells = ((grid_cells > 40) ? 1 : $urandom_range(1, 3)) * grid_cells;
        if (grid_cells > 1 && $urandom_range(0, 4) == 0)
          n_cells += $urandom_range(1, grid_cells - 1);
      end
      // keep the random part close to its planned length
      if (n_cells > RAND_CELLS - rand_cells)
        n_cells = RAND_CELLS - rand_cells;

      repeat (n_cells)
        push_cell(draw_elev(terrain, flat_level), 1'b0, NO_PEAK);
      rand_cells += n_cells;
      phase++;
    end

    drain();

    $display("sent %0d cells (%0d random) across %0d random grid settings, %0d register writes",
             cells_sent, rand_cells, phase, cfg_writes);
    $display("checked %0d peak transfers, %0d mismatches", peaks_seen, mismatches);
    if (mismatches == 0)
      $display("grid_local_peak_finder_top test passed");
    else
      $display("grid_local_peak_finder_top test failed");
    $finish;
  end

endmodule
